// File: rtl/kvcl_pkg.sv
// kvcl_pkg: shared types and constants for the key/value config lexer.
// No dependencies; imported by every other file of the block.
`default_nettype none

package kvcl_pkg;

  // parse modes
  localparam logic [2:0] MODE_INITIAL  = 3'd0;
  localparam logic [2:0] MODE_COMMENT  = 3'd1;
  localparam logic [2:0] MODE_QUOTED   = 3'd2;
  localparam logic [2:0] MODE_UNQUOTED = 3'd3;
  localparam logic [2:0] MODE_SKIP     = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_KEY   = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_WARN  = 2'd3;

  // input func codes
  localparam logic FUNC_TEXT = 1'b0;
  localparam logic FUNC_EOF  = 1'b1;

  // config register indexes
  localparam logic [1:0] REG_COMMENT   = 2'd0;
  localparam logic [1:0] REG_SEPARATOR = 2'd1;
  localparam logic [1:0] REG_QUOTE     = 2'd2;

  localparam logic [7:0] COMMENT_RESET   = 8'd35;
  localparam logic [7:0] SEPARATOR_RESET = 8'd61;
  localparam logic [7:0] QUOTE_RESET     = 8'd34;

  localparam logic [7:0]  NEWLINE_BYTE = 8'd10;
  localparam logic [7:0]  ZERO_BYTE    = 8'd0;
  localparam logic [15:0] LINE_FIRST   = 16'd1;
  localparam logic [15:0] LINE_MAX     = 16'hFFFF;

  typedef struct packed {
    logic [7:0] comment_byte;
    logic [7:0] separator_char;
    logic [7:0] quote_char;
  } cfg_regs_t;

  // per-line parser state (token length is kept apart, its width is a parameter)
  typedef struct packed {
    logic [2:0]  parse_mode;
    logic        in_value;
    logic        key_nonempty;
    logic [15:0] line_count;
  } line_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  char_value;
    logic        accepted;
    logic [15:0] line_number;
  } result_t;

  // up to two results caused by one input transaction
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } result_pair_t;

endpackage

`default_nettype wire

// File: rtl/kvcl_step.sv
// kvcl_step: one parser step, combinational: state and byte in, next state
// and zero to two results out. Depends on kvcl_pkg.
`default_nettype none

module kvcl_step import kvcl_pkg::*; #(
  parameter int TOKEN_BYTES = 128,
  parameter int LEN_W       = 7
) (
  input  wire  cfg_regs_t    cfg,
  input  wire  line_state_t  cur,
  input  wire  [LEN_W-1:0]   token_length,
  input  wire                func,
  input  wire  [7:0]         text_byte,
  output line_state_t        nxt,
  output logic [LEN_W-1:0]   token_length_next,
  output result_pair_t       pair
);

  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(TOKEN_BYTES - 1);

  function automatic logic is_blank(input logic [7:0] b);
    return (b == 8'd32) || (b == 8'd9) || (b == 8'd11) || (b == 8'd12) || (b == 8'd13);
  endfunction

  logic do_keep, do_end, do_warn, do_sep;
  logic room;
  result_t end_res, warn_res, char_res;

  always_comb begin
    do_keep = 1'b0;
    do_end  = 1'b0;
    do_warn = 1'b0;
    do_sep  = 1'b0;
    nxt = cur;
    token_length_next = token_length;
    room = token_length < LEN_LIMIT;

    case (cur.parse_mode)
      MODE_COMMENT, MODE_SKIP: begin
        do_end = (text_byte == NEWLINE_BYTE);
      end
      MODE_QUOTED: begin
        if (text_byte == cfg.quote_char) begin
          nxt.parse_mode = MODE_INITIAL;
        end else if (text_byte == NEWLINE_BYTE) begin
          do_warn = 1'b1;
          do_end  = 1'b1;
        end else begin
          do_keep = 1'b1;
        end
      end
      MODE_UNQUOTED: begin
        if (text_byte == cfg.comment_byte) begin
          nxt.parse_mode = MODE_COMMENT;
        end else if (text_byte == NEWLINE_BYTE) begin
          do_end = 1'b1;
        end else if (text_byte == cfg.separator_char) begin
          do_sep = 1'b1;
        end else if (is_blank(text_byte)) begin
          nxt.parse_mode = MODE_INITIAL;
        end else begin
          do_keep = 1'b1;
        end
      end
      default: begin
        // initial mode, also unused codes
        if (text_byte == cfg.comment_byte) begin
          nxt.parse_mode = MODE_COMMENT;
        end else if (text_byte == cfg.quote_char) begin
          nxt.parse_mode = MODE_QUOTED;
        end else if (text_byte == NEWLINE_BYTE) begin
          do_end = 1'b1;
        end else if (text_byte == cfg.separator_char) begin
          do_sep = 1'b1;
        end else if (!is_blank(text_byte)) begin
          do_keep = 1'b1;
          nxt.parse_mode = MODE_UNQUOTED;
        end
      end
    endcase

    if (do_keep && room) begin
      token_length_next = token_length + LEN_W'(1);
      if (!cur.in_value) nxt.key_nonempty = 1'b1;
    end

    if (do_sep) begin
      if (cur.in_value) begin
        nxt.parse_mode = MODE_SKIP;
      end else begin
        nxt.in_value = 1'b1;
        nxt.parse_mode = MODE_INITIAL;
        token_length_next = '0;
      end
    end

    if (do_end || func == FUNC_EOF) begin
      nxt.parse_mode   = MODE_INITIAL;
      nxt.in_value     = 1'b0;
      nxt.key_nonempty = 1'b0;
      token_length_next = '0;
      if (func == FUNC_EOF) nxt.line_count = LINE_FIRST;
      else if (cur.line_count != LINE_MAX) nxt.line_count = cur.line_count + 16'd1;
    end
  end

  always_comb begin
    end_res.kind        = KIND_END;
    end_res.char_value  = ZERO_BYTE;
    end_res.accepted    = cur.key_nonempty;
    end_res.line_number = cur.line_count;

    warn_res.kind        = KIND_WARN;
    warn_res.char_value  = ZERO_BYTE;
    warn_res.accepted    = 1'b0;
    warn_res.line_number = cur.line_count;

    char_res.kind        = cur.in_value ? KIND_VALUE : KIND_KEY;
    char_res.char_value  = text_byte;
    char_res.accepted    = 1'b0;
    char_res.line_number = cur.line_count;

    pair.res0  = end_res;
    pair.res1  = end_res;
    pair.count = 2'd0;
    if (func == FUNC_EOF) begin
      pair.count = 2'd1;
    end else if (do_warn) begin
      pair.res0  = warn_res;
      pair.count = 2'd2;
    end else if (do_end) begin
      pair.count = 2'd1;
    end else if (do_keep && room) begin
      pair.res0  = char_res;
      pair.count = 2'd1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/kvcl_res_fifo.sv
// kvcl_res_fifo: two-entry queue of result pairs; unrolls each pair into
// one or two output transactions. Depends on kvcl_pkg.
`default_nettype none

module kvcl_res_fifo import kvcl_pkg::*; (
  input  wire           clk,
  input  wire           rst,
  input  wire           push,
  input  wire  result_pair_t push_pair,
  output logic          has_room,
  output logic          out_valid,
  input  wire           out_stall,
  output result_t       out_res,
  output logic          out_last
);

  result_pair_t mem [2];
  logic       wr_ptr, rd_ptr, sub;
  logic [1:0] count;
  result_pair_t head;
  logic pop_res, pop_pair;

  assign head      = mem[rd_ptr];
  assign has_room  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_last  = sub || (head.count == 2'd1);
  assign out_res   = sub ? head.res1 : head.res0;
  assign pop_res   = out_valid && !out_stall;
  assign pop_pair  = pop_res && out_last;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_pair;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      sub    <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop_pair) rd_ptr <= ~rd_ptr;
      if (pop_res) sub <= !out_last;
      case ({push, pop_pair})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != 2'd2))
    else $error("result queue written while full");

endmodule

`default_nettype wire

// File: rtl/key_value_config_lexer_core.sv
// key_value_config_lexer_core: top level of the key/value config lexer.
// Depends on kvcl_pkg, kvcl_step and kvcl_res_fifo.
`default_nettype none

// Channel  Direction  Handshake            Payload
// -------  ---------  -------------------  ----------------------------------------
// in       input      in_valid / in_stall  func, text_byte
// out      output     out_valid/out_stall  kind, char_value, accepted, line_number, last
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One input transaction per cycle while in_stall is low: a byte is held in the input
// register, then one parser step moves it into the two-entry result queue.
// A byte that yields two results (open quote at newline) holds the output for
// two transactions; the queue lets the input keep flowing while results wait.
// On its way to out, a byte passes the input register and then the result queue.
// rst is synchronous: parser state back to line 1, registers to '#', '=', '"'.
// in_stall rises only while the input register is full and the queue is full.

module key_value_config_lexer_core import kvcl_pkg::*; #(
  parameter int TOKEN_BYTES = 128
) (
  input  wire         clk,
  input  wire         rst,
  // input text
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         func,
  input  wire  [7:0]  text_byte,
  // results
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  char_value,
  output logic        accepted,
  output logic [15:0] line_number,
  output logic        last,
  // configuration writes
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [7:0]  cfg_data
);

  // token length counts up to TOKEN_BYTES-1
  localparam int LEN_W = (TOKEN_BYTES > 2) ? $clog2(TOKEN_BYTES) : 1;
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(TOKEN_BYTES - 1);

  cfg_regs_t    cfg;
  line_state_t  state, state_next;
  logic [LEN_W-1:0] token_length, token_length_next;
  result_pair_t pair;
  result_t      out_res;

  // input register
  logic       in_q_valid;
  logic       func_q;
  logic [7:0] byte_q;

  logic q_room, advance, in_take;

  assign cfg_ready = 1'b1;
  assign advance   = in_q_valid && q_room;
  assign in_stall  = in_q_valid && !q_room;
  assign in_take   = in_valid && !in_stall;

  // configuration registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.comment_byte   <= COMMENT_RESET;
      cfg.separator_char <= SEPARATOR_RESET;
      cfg.quote_char     <= QUOTE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COMMENT:   cfg.comment_byte   <= cfg_data;
        REG_SEPARATOR: cfg.separator_char <= cfg_data;
        REG_QUOTE:     cfg.quote_char     <= cfg_data;
        default:       ; // unknown index: dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      func_q <= func;
      byte_q <= text_byte;
    end
  end

  kvcl_step #(
    .TOKEN_BYTES (TOKEN_BYTES),
    .LEN_W       (LEN_W)
  ) u_step (
    .cfg               (cfg),
    .cur               (state),
    .token_length      (token_length),
    .func              (func_q),
    .text_byte         (byte_q),
    .nxt               (state_next),
    .token_length_next (token_length_next),
    .pair              (pair)
  );

  // parser state moves only when the registered byte is stepped, which needs room in the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      state.parse_mode   <= MODE_INITIAL;
      state.in_value     <= 1'b0;
      state.key_nonempty <= 1'b0;
      state.line_count   <= LINE_FIRST;
      token_length       <= '0;
    end else if (advance) begin
      state        <= state_next;
      token_length <= token_length_next;
    end
  end

  kvcl_res_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (advance && (pair.count != 2'd0)),
    .push_pair (pair),
    .has_room  (q_room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res),
    .out_last  (last)
  );

  assign kind        = out_res.kind;
  assign char_value  = out_res.char_value;
  assign accepted    = out_res.accepted;
  assign line_number = out_res.line_number;

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    state.line_count != 16'd0)
    else $error("line count reached zero");

  a_key_len_consistent: assert property (@(posedge clk) disable iff (rst)
    (!state.in_value && !state.key_nonempty) |-> (token_length == '0))
    else $error("key length nonzero with empty key");

  a_len_saturates: assert property (@(posedge clk) disable iff (rst)
    (advance && token_length == LEN_LIMIT) |=>
      (token_length == LEN_LIMIT || token_length == '0))
    else $error("token length grew past limit");

endmodule

`default_nettype wire

// File: tb/key_value_config_lexer_core_tb.sv
// Self-checking testbench for key_value_config_lexer_core: a text stream in, key/value tokens out.
// Needs kvcl_pkg and the lexer RTL only. A built-in predictor checks every result
// transaction field by field, across several comment/separator/quote settings.
`timescale 1ns / 100ps

module key_value_config_lexer_core_tb import kvcl_pkg::*;;

  localparam int TOKEN_BYTES = 128;
  localparam int STALL_LIMIT = 4000;  // cycles without any accepted transaction
  localparam int PHASE_ITEMS = 270;
  localparam logic [1:0] REG_UNUSED = 2'd3;  // index with no register behind it

  // one input transaction
  typedef struct packed {
    logic       is_eof;
    logic [7:0] data;
  } text_item_t;

  // one result transaction, as predicted
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  ch;
    logic        acc;
    logic [15:0] line;
    logic        last;
  } lex_token_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        func = FUNC_TEXT;
  logic [7:0]  text_byte = ZERO_BYTE;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  char_value;
  logic        accepted;
  logic [15:0] line_number;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_COMMENT;
  logic [7:0]  cfg_data = ZERO_BYTE;

  key_value_config_lexer_core #(.TOKEN_BYTES(TOKEN_BYTES)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .text_byte(text_byte),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .char_value(char_value),
    .accepted(accepted), .line_number(line_number), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stimulus and scoreboard storage
  text_item_t text_queue[$];       // input transactions not yet presented
  text_item_t next_item;
  lex_token_t expected_tokens[$];  // predicted results, oldest first
  lex_token_t step_tokens[$];      // results of the byte being predicted
  int         idle_pct = 13;       // chance in a hundred of a gap / stall per cycle
  int         live_items = 0;      // items that can change parser state
  int         errors = 0;

  // ---------------------------------------------------------------------------
  // Lexer predictor: its own copy of registers and line state
  // ---------------------------------------------------------------------------
  cfg_regs_t   lex_regs;
  logic [2:0]  lex_mode;
  logic        in_value_part;   // 0 while collecting the key
  int          tok_len;         // kept chars in the current token
  logic        key_seen;
  logic [15:0] line_no;

  function automatic logic is_blank(input logic [7:0] b);
    case (b)
      8'd32, 8'd9, 8'd11, 8'd12, 8'd13: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic emit(input logic [1:0] k, input logic [7:0] c, input logic a);
    lex_token_t t;
    t.kind = k;
    t.ch   = c;
    t.acc  = a;
    t.line = line_no;
    t.last = 1'b0;
    step_tokens.push_back(t);
  endtask

  task automatic clear_line();
    lex_mode      = MODE_INITIAL;
    in_value_part = 1'b0;
    tok_len       = 0;
    key_seen      = 1'b0;
  endtask

  // record end carries the number of the line that closes, then the count moves on
  task automatic finish_line();
    emit(KIND_END, ZERO_BYTE, key_seen);
    clear_line();
    if (line_no != LINE_MAX) line_no++;
  endtask

  // chars past TOKEN_BYTES-1 in one token vanish without a result
  task automatic keep_char(input logic [7:0] b);
    if (tok_len < TOKEN_BYTES - 1) begin
      emit(in_value_part ? KIND_VALUE : KIND_KEY, b, 1'b0);
      tok_len++;
      if (!in_value_part) key_seen = 1'b1;
    end
  endtask

  // first separator opens the value, a second one skips the rest of the line
  task automatic take_separator();
    if (in_value_part) begin
      lex_mode = MODE_SKIP;
    end else begin
      in_value_part = 1'b1;
      tok_len       = 0;
      lex_mode      = MODE_INITIAL;
    end
  endtask

  task automatic lex_step(input logic f, input logic [7:0] b);
    lex_token_t t;
    step_tokens.delete();
    if (f == FUNC_EOF) begin
      // flush: one record end, no quote warning, back to line 1
      emit(KIND_END, ZERO_BYTE, key_seen);
      clear_line();
      line_no = LINE_FIRST;
    end else begin
      case (lex_mode)
        MODE_COMMENT, MODE_SKIP: begin
          if (b == NEWLINE_BYTE) finish_line();
        end
        MODE_QUOTED: begin
          if (b == lex_regs.quote_char) begin
            lex_mode = MODE_INITIAL;
          end else if (b == NEWLINE_BYTE) begin
            emit(KIND_WARN, ZERO_BYTE, 1'b0);  // open quote: warning goes first
            finish_line();
          end else begin
            keep_char(b);
          end
        end
        MODE_UNQUOTED: begin
          // a quote byte is a literal here
          if (b == lex_regs.comment_byte) lex_mode = MODE_COMMENT;
          else if (b == NEWLINE_BYTE) finish_line();
          else if (b == lex_regs.separator_char) take_separator();
          else if (is_blank(b)) lex_mode = MODE_INITIAL;
          else keep_char(b);
        end
        default: begin
          // initial mode, and the unused mode codes
          if (b == lex_regs.comment_byte) begin
            lex_mode = MODE_COMMENT;
          end else if (b == lex_regs.quote_char) begin
            lex_mode = MODE_QUOTED;
          end else if (b == NEWLINE_BYTE) begin
            finish_line();
          end else if (b == lex_regs.separator_char) begin
            take_separator();
          end else if (!is_blank(b)) begin
            keep_char(b);
            lex_mode = MODE_UNQUOTED;
          end
        end
      endcase
    end
    foreach (step_tokens[i]) begin
      t = step_tokens[i];
      t.last = (i == step_tokens.size() - 1);
      expected_tokens.push_back(t);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued items, random gaps; predicts at each acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) lex_step(func, text_byte);
      // payload held while stalled
      if (!in_valid || !in_stall) begin
        if (text_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_item = text_queue.pop_front();
          in_valid  <= 1'b1;
          func      <= next_item.is_eof;
          text_byte <= next_item.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, compares each result with the oldest prediction
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  lex_token_t want_tok;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_tokens.size() == 0) begin
          $error("result with none predicted: kind %0d char %0d line %0d",
                 kind, char_value, line_number);
          errors++;
        end else begin
          want_tok = expected_tokens.pop_front();
          check_field("kind", 16'(want_tok.kind), 16'(kind));
          check_field("char_value", 16'(want_tok.ch), 16'(char_value));
          check_field("accepted", 16'(want_tok.acc), 16'(accepted));
          check_field("line_number", want_tok.line, line_number);
          check_field("last", 16'(want_tok.last), 16'(last));
        end
      end
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  // Watchdog: ends the run if no channel moves a transaction for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Text generation (uses the current register values so lines are well formed)
  // ---------------------------------------------------------------------------
  task automatic feed(input logic [7:0] b, input bit counted = 1'b1);
    text_item_t t;
    t.is_eof = FUNC_TEXT;
    t.data   = b;
    text_queue.push_back(t);
    if (counted) live_items++;
  endtask

  // text_byte is don't-care on end of input, so randomize it
  task automatic feed_eof();
    text_item_t t;
    t.is_eof = FUNC_EOF;
    t.data   = 8'($urandom_range(255));
    text_queue.push_back(t);
    live_items++;
  endtask

  function automatic logic [7:0] blank_char();
    case ($urandom_range(4))
      0: return 8'd9;
      1: return 8'd11;
      2: return 8'd12;
      3: return 8'd13;
      default: return 8'd32;
    endcase
  endfunction

  // any byte with no special meaning under the current registers
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do begin
      c = ($urandom_range(1) == 0) ? 8'($urandom_range(126, 33)) : 8'($urandom_range(255));
    end while (c == lex_regs.comment_byte || c == lex_regs.separator_char ||
               c == lex_regs.quote_char || c == NEWLINE_BYTE || is_blank(c));
    return c;
  endfunction

  // mostly short tokens, now and then a long one around the token limit
  function automatic int token_len(input int lo);
    return ($urandom_range(29) == 0) ? $urandom_range(135, 120) : $urandom_range(6, lo);
  endfunction

  task automatic feed_word(input int n);
    repeat (n) feed(plain_char());
  endtask

  task automatic feed_blanks(input int n);
    repeat (n) feed(blank_char());
  endtask

  // comment body bytes are not counted; the lexer ignores them unless one is a newline
  task automatic feed_comment();
    feed(lex_regs.comment_byte);
    repeat ($urandom_range(4)) feed(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic gen_line();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      // well-formed line with random content
      feed_blanks($urandom_range(2));
      feed_word(token_len(1));
      feed_blanks($urandom_range(1));
      if ($urandom_range(9) != 0) begin
        feed(lex_regs.separator_char);
        feed_blanks($urandom_range(1));
        if ($urandom_range(3) == 0) begin
          // quoted value: blanks and specials are literal inside
          feed(lex_regs.quote_char);
          repeat ($urandom_range(6)) begin
            case ($urandom_range(3))
              0: feed(blank_char());
              1: feed(($urandom_range(1) == 0) ? lex_regs.separator_char
                                               : lex_regs.comment_byte);
              default: feed(plain_char());
            endcase
          end
          if ($urandom_range(7) != 0) feed(lex_regs.quote_char);
        end else begin
          feed_word(token_len(0));
        end
        if ($urandom_range(9) == 0) begin
          feed(lex_regs.separator_char);  // second separator: rest of line skipped
          feed_word(2);
        end
      end
      feed_blanks($urandom_range(1));
      if ($urandom_range(4) == 0) feed_comment();
      feed(NEWLINE_BYTE);
    end else if (pick < 85) begin
      // raw noise
      repeat ($urandom_range(10, 1)) feed(8'($urandom_range(255)));
      if ($urandom_range(1) == 0) feed(NEWLINE_BYTE);
    end else if (pick < 90) begin
      feed_eof();
    end else begin
      case ($urandom_range(3))
        0: begin
          feed_word(token_len(1));
          feed_eof();  // end of input in mid-line
        end
        1: begin
          feed(lex_regs.quote_char);  // quote left open at newline
          feed_word(3);
          feed(NEWLINE_BYTE);
        end
        2: begin
          feed_comment();
          feed(NEWLINE_BYTE);
        end
        default: feed(NEWLINE_BYTE);
      endcase
    end
  endtask

  task automatic random_text(input int n);
    int goal;
    @(negedge clk);
    goal = live_items + n;
    do gen_line();
    while (live_items < goal);
  endtask

  // Wait for the block to go idle, then let it settle.
  task automatic drain();
    do @(negedge clk);
    while (text_queue.size() != 0 || in_valid || expected_tokens.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Writes all three char registers plus the unused index; called at a rising edge.
  task automatic set_chars(input logic [7:0] c, input logic [7:0] s, input logic [7:0] q);
    logic [1:0] ids [4];
    logic [7:0] vals [4];
    ids  = '{REG_COMMENT, REG_SEPARATOR, REG_QUOTE, REG_UNUSED};
    vals = '{c, s, q, 8'($urandom_range(255))};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= ids[i];
      cfg_data  <= vals[i];
      do @(posedge clk);
      while (!cfg_ready);
      case (ids[i])
        REG_COMMENT:   lex_regs.comment_byte   = vals[i];
        REG_SEPARATOR: lex_regs.separator_char = vals[i];
        REG_QUOTE:     lex_regs.quote_char     = vals[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    lex_regs.comment_byte   = COMMENT_RESET;
    lex_regs.separator_char = SEPARATOR_RESET;
    lex_regs.quote_char     = QUOTE_RESET;
    clear_line();
    line_no = LINE_FIRST;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset register values
    @(negedge clk);
    feed("a"); feed(SEPARATOR_RESET); feed("b"); feed(NEWLINE_BYTE);  // plain record
    feed(SEPARATOR_RESET); feed("v"); feed(NEWLINE_BYTE);              // empty key
    feed(QUOTE_RESET); feed(" "); feed("q"); feed(NEWLINE_BYTE);       // open quote at newline
    feed("k"); feed(SEPARATOR_RESET); feed("x");                       // second separator
    feed(SEPARATOR_RESET); feed("y"); feed(NEWLINE_BYTE);
    feed("k"); feed(COMMENT_RESET); feed("z"); feed(NEWLINE_BYTE);     // trailing comment
    feed(ZERO_BYTE); feed(8'hFF); feed(NEWLINE_BYTE);                  // zero byte is a char
    feed_eof();
    random_text(PHASE_ITEMS);

    // Other usual chars
    drain();
    set_chars(";", ":", "'");
    random_text(PHASE_ITEMS);

    // Extremes; with newline as quote, it opens/closes quotes, in other modes it ends lines
    drain();
    set_chars(8'h00, 8'hFF, NEWLINE_BYTE);
    random_text(PHASE_ITEMS);

    // Comment and quote collide (comment wins); zero byte separates
    drain();
    set_chars(8'hFF, 8'h00, 8'hFF);
    random_text(PHASE_ITEMS);

    // Comment on newline, quote on space
    drain();
    set_chars(NEWLINE_BYTE, NEWLINE_BYTE, 8'd32);
    random_text(PHASE_ITEMS);

    // Back to defaults by explicit writes; this stretch runs with no input gaps or output stalls
    drain();
    set_chars(COMMENT_RESET, SEPARATOR_RESET, QUOTE_RESET);
    idle_pct = 0;
    random_text(PHASE_ITEMS);

    drain();
    repeat (8) @(posedge clk);  // any extra result would show up here
    @(negedge clk);
    if (errors == 0 && expected_tokens.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
